### design/tsrr_pkg.sv
// ============================================================================
// tsrr_pkg
// Shared constants, codes and types of the task slot round-robin scheduler.
// ============================================================================
`default_nettype none

package tsrr_pkg;

    // Table size and derived widths.
    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Field widths of the request and response transactions.
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 5;
    localparam int TID_W    = 32;
    localparam int STATUS_W = 2;

    // Command queue between the front and back ends.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_SCHED,
        OP_MARK,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_NEW     = 2'd1,
        SLOT_READY   = 2'd2,
        SLOT_RUNNING = 2'd3
    } t_slot_st;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NO_READY = 2'd2,
        ST_NOT_NEW  = 2'd3
    } t_status;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } t_cmd;

endpackage

`default_nettype wire

### design/tsrr_req_if.sv
// ============================================================================
// tsrr_req_if
// Request channel: valid/ready handshake carrying function and slot index.
// ============================================================================
`default_nettype none

interface tsrr_req_if;
    logic                        valid;
    logic                        ready;
    logic [tsrr_pkg::FUNC_W-1:0] func;
    logic [tsrr_pkg::IDX_W-1:0]  slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);
endinterface

`default_nettype wire

### design/tsrr_rsp_if.sv
// ============================================================================
// tsrr_rsp_if
// Response channel: valid/ready handshake carrying the result of one request.
// ============================================================================
`default_nettype none

interface tsrr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsrr_pkg::STATUS_W-1:0] status;
    logic [tsrr_pkg::IDX_W-1:0]    result_slot;
    logic [tsrr_pkg::TID_W-1:0]    thread_id;
    logic                          switched;

    modport source (output valid, output status, output result_slot,
                    output thread_id, output switched, input ready);
    modport sink   (input valid, input status, input result_slot,
                    input thread_id, input switched, output ready);
endinterface

`default_nettype wire

### design/tsrr_ram.sv
// ============================================================================
// tsrr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module tsrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/tsrr_front.sv
// ============================================================================
// tsrr_front
// Accepts requests, decodes them into commands and queues them for the back end.
// ============================================================================
`default_nettype none

module tsrr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tsrr_req_if.sink            i_req,
    output tsrr_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_pop
);

    tsrr_pkg::t_cmd                    r_mem [tsrr_pkg::QDEPTH];
    logic [tsrr_pkg::QPTR_W-1:0]       r_wptr, n_wptr;
    logic [tsrr_pkg::QPTR_W-1:0]       r_rptr, n_rptr;
    logic [tsrr_pkg::QCNT_W-1:0]       r_count, n_count;
    tsrr_pkg::t_cmd                    dec_cmd;
    logic                              push;
    logic                              pop;

    // Classify the incoming request.
    always_comb begin
        dec_cmd.idx      = i_req.slot_index;
        dec_cmd.in_range = (32'(i_req.slot_index) < tsrr_pkg::NUM_SLOTS);
        unique case (i_req.func)
            tsrr_pkg::FUNC_ALLOC: dec_cmd.op = tsrr_pkg::OP_ALLOC;
            tsrr_pkg::FUNC_SCHED: dec_cmd.op = tsrr_pkg::OP_SCHED;
            tsrr_pkg::FUNC_MARK:  dec_cmd.op = tsrr_pkg::OP_MARK;
            default:              dec_cmd.op = tsrr_pkg::OP_NOP;
        endcase
    end

    assign i_req.ready = (r_count != tsrr_pkg::QCNT_W'(tsrr_pkg::QDEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == tsrr_pkg::QPTR_W'(tsrr_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == tsrr_pkg::QPTR_W'(tsrr_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (push) begin
            r_mem[r_wptr] <= dec_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsrr_pkg::QCNT_W'(tsrr_pkg::QDEPTH))
        else $error("Command queue count exceeds its depth.");

endmodule

`default_nettype wire

### design/tsrr_back.sv
// ============================================================================
// tsrr_back
// Executes queued commands against the slot table, one slot per cycle.
// ============================================================================
`default_nettype none

module tsrr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tsrr_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    tsrr_rsp_if.source          o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    localparam int SW = tsrr_pkg::SLOT_W;
    localparam int CW = tsrr_pkg::CNT_W;

    t_state                        r_state, n_state;
    tsrr_pkg::t_op                 r_op, n_op;
    logic [tsrr_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                          r_in_range, n_in_range;
    logic [SW-1:0]                 r_ptr, n_ptr;
    logic [CW-1:0]                 r_cnt, n_cnt;
    tsrr_pkg::t_slot_st            r_slot_state [tsrr_pkg::NUM_SLOTS];
    tsrr_pkg::t_slot_st            n_slot_state [tsrr_pkg::NUM_SLOTS];
    logic [SW-1:0]                 r_running_slot, n_running_slot;
    logic                          r_running_valid, n_running_valid;
    logic [tsrr_pkg::TID_W-1:0]    r_next_tid, n_next_tid;

    tsrr_pkg::t_status             r_res_status, n_res_status;
    logic [tsrr_pkg::IDX_W-1:0]    r_res_slot, n_res_slot;
    logic [tsrr_pkg::TID_W-1:0]    r_res_tid, n_res_tid;
    logic                          r_res_sw, n_res_sw;

    logic                          r_out_valid, n_out_valid;
    tsrr_pkg::t_status             r_out_status, n_out_status;
    logic [tsrr_pkg::IDX_W-1:0]    r_out_slot, n_out_slot;
    logic [tsrr_pkg::TID_W-1:0]    r_out_tid, n_out_tid;
    logic                          r_out_sw, n_out_sw;

    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    logic [tsrr_pkg::TID_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [SW-1:0]                 ram_raddr;
    logic [tsrr_pkg::TID_W-1:0]    ram_rdata;

    logic [SW-1:0]                 mark_slot;
    logic [SW-1:0]                 rd_addr;
    tsrr_pkg::t_slot_st            rd_st;
    logic                          last;
    logic [SW-1:0]                 ptr_inc;
    logic [SW-1:0]                 run_inc;

    tsrr_ram #(
        .WIDTH (tsrr_pkg::TID_W),
        .DEPTH (tsrr_pkg::NUM_SLOTS)
    ) u_tid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign mark_slot = SW'(r_idx);
    assign rd_addr   = (r_op == tsrr_pkg::OP_MARK) ? mark_slot : r_ptr;
    assign rd_st     = r_slot_state[rd_addr];
    assign last      = (r_cnt == CW'(1));
    assign ptr_inc   = (r_ptr == SW'(tsrr_pkg::NUM_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign run_inc   = (r_running_slot == SW'(tsrr_pkg::NUM_SLOTS - 1)) ? '0
                                                                         : r_running_slot + 1'b1;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_slot = r_out_slot;
    assign o_rsp.thread_id   = r_out_tid;
    assign o_rsp.switched    = r_out_sw;

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_idx           = r_idx;
        n_in_range      = r_in_range;
        n_ptr           = r_ptr;
        n_cnt           = r_cnt;
        n_slot_state    = r_slot_state;
        n_running_slot  = r_running_slot;
        n_running_valid = r_running_valid;
        n_next_tid      = r_next_tid;
        n_res_status    = r_res_status;
        n_res_slot      = r_res_slot;
        n_res_tid       = r_res_tid;
        n_res_sw        = r_res_sw;
        n_out_valid     = r_out_valid;
        n_out_status    = r_out_status;
        n_out_slot      = r_out_slot;
        n_out_tid       = r_out_tid;
        n_out_sw        = r_out_sw;
        o_cmd_pop       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_ptr;
        ram_wdata       = r_next_tid;
        ram_re          = 1'b0;
        ram_raddr       = r_ptr;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_op       = i_cmd.op;
                    n_idx      = i_cmd.idx;
                    n_in_range = i_cmd.in_range;
                    // With a task running, a schedule scans the other slots, starting after the running one.
                    if (i_cmd.op == tsrr_pkg::OP_SCHED && r_running_valid) begin
                        n_ptr = run_inc;
                        n_cnt = CW'(tsrr_pkg::NUM_SLOTS - 1);
                    end else begin
                        n_ptr = '0;
                        n_cnt = CW'(tsrr_pkg::NUM_SLOTS);
                    end
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_op)
                    tsrr_pkg::OP_ALLOC: begin
                        if (rd_st == tsrr_pkg::SLOT_FREE) begin
                            n_slot_state[r_ptr] = tsrr_pkg::SLOT_NEW;
                            ram_we       = 1'b1;
                            n_res_status = tsrr_pkg::ST_DONE;
                            n_res_slot   = tsrr_pkg::IDX_W'(r_ptr);
                            n_res_tid    = r_next_tid;
                            n_res_sw     = 1'b0;
                            n_next_tid   = r_next_tid + 1'b1;
                            n_state      = S_DONE;
                        end else if (last) begin
                            n_res_status = tsrr_pkg::ST_NO_FREE;
                            n_res_slot   = '0;
                            n_res_tid    = '0;
                            n_res_sw     = 1'b0;
                            n_state      = S_DONE;
                        end else begin
                            n_ptr = ptr_inc;
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    tsrr_pkg::OP_SCHED: begin
                        if (rd_st == tsrr_pkg::SLOT_READY) begin
                            if (r_running_valid) begin
                                n_slot_state[r_running_slot] = tsrr_pkg::SLOT_READY;
                            end
                            n_slot_state[r_ptr] = tsrr_pkg::SLOT_RUNNING;
                            n_running_slot  = r_ptr;
                            n_running_valid = 1'b1;
                            n_res_status    = tsrr_pkg::ST_DONE;
                            n_res_slot      = tsrr_pkg::IDX_W'(r_ptr);
                            n_res_sw        = 1'b1;
                            ram_re          = 1'b1;
                            ram_raddr       = r_ptr;
                            n_state         = S_READ;
                        end else if (last) begin
                            n_res_status = tsrr_pkg::ST_NO_READY;
                            n_res_sw     = 1'b0;
                            if (r_running_valid) begin
                                // The current task keeps running and is reported.
                                n_res_slot = tsrr_pkg::IDX_W'(r_running_slot);
                                ram_re     = 1'b1;
                                ram_raddr  = r_running_slot;
                                n_state    = S_READ;
                            end else begin
                                n_res_slot = '0;
                                n_res_tid  = '0;
                                n_state    = S_DONE;
                            end
                        end else begin
                            n_ptr = ptr_inc;
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    tsrr_pkg::OP_MARK: begin
                        n_res_slot = r_idx;
                        n_res_sw   = 1'b0;
                        if (r_in_range && rd_st == tsrr_pkg::SLOT_NEW) begin
                            n_slot_state[mark_slot] = tsrr_pkg::SLOT_READY;
                            n_res_status = tsrr_pkg::ST_DONE;
                            ram_re       = 1'b1;
                            ram_raddr    = mark_slot;
                            n_state      = S_READ;
                        end else begin
                            n_res_status = tsrr_pkg::ST_NOT_NEW;
                            n_res_tid    = '0;
                            n_state      = S_DONE;
                        end
                    end
                    tsrr_pkg::OP_NOP: begin
                        n_res_status = tsrr_pkg::ST_DONE;
                        n_res_slot   = '0;
                        n_res_tid    = '0;
                        n_res_sw     = 1'b0;
                        n_state      = S_DONE;
                    end
                endcase
            end

            S_READ: begin
                n_res_tid = ram_rdata;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_tid    = r_res_tid;
                    n_out_sw     = r_res_sw;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_op            <= tsrr_pkg::OP_NOP;
            r_cnt           <= '0;
            r_running_slot  <= '0;
            r_running_valid <= 1'b0;
            r_next_tid      <= tsrr_pkg::TID_W'(1);
            r_out_valid     <= 1'b0;
            for (int i = 0; i < tsrr_pkg::NUM_SLOTS; i++) begin
                r_slot_state[i] <= tsrr_pkg::SLOT_FREE;
            end
        end else begin
            r_state         <= n_state;
            r_op            <= n_op;
            r_cnt           <= n_cnt;
            r_running_slot  <= n_running_slot;
            r_running_valid <= n_running_valid;
            r_next_tid      <= n_next_tid;
            r_out_valid     <= n_out_valid;
            r_slot_state    <= n_slot_state;
        end
        r_idx        <= n_idx;
        r_in_range   <= n_in_range;
        r_ptr        <= n_ptr;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_tid    <= n_res_tid;
        r_res_sw     <= n_res_sw;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_tid    <= n_out_tid;
        r_out_sw     <= n_out_sw;
    end

    a_running_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running_valid |-> r_slot_state[r_running_slot] == tsrr_pkg::SLOT_RUNNING)
        else $error("Running slot is not marked running in the table.");

    a_switch_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sw) |-> r_out_status == tsrr_pkg::ST_DONE)
        else $error("Task switch reported with an error status.");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("Response register loaded outside the completion state.");

endmodule

`default_nettype wire

### design/task_slot_round_robin_scheduler.sv
// ============================================================================
// task_slot_round_robin_scheduler
// Task slot table with allocate, mark-ready and round-robin schedule requests.
// ============================================================================
// The back end takes one request at a time from the command queue; its slot
// scan visits one slot per cycle, and the result passes through the result
// registers into the response register. Two more requests can wait in the
// command queue meanwhile.
// Reset (synchronous, active low) frees every slot, clears the running task
// and sets the thread id counter to one; there is no clearing pass.
`default_nettype none

module task_slot_round_robin_scheduler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsrr_req_if.sink    i_req,
    tsrr_rsp_if.source  o_rsp
);

    // Commands travel from the decoding front end to the executing back end
    // through a small queue, so requests keep being accepted during a scan
    // until the queue is full.
    tsrr_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // The front end takes each request transaction, classifies the function
    // code and checks the slot index against the table size.
    tsrr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // The back end owns the slot states, the thread id memory, the running
    // task and the id counter. It walks the table one slot per cycle and
    // leaves each result in a response register, which is taken as a
    // response transaction while the next command may already be scanning.
    tsrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// ============================================================================
// tb
// Self-checking testbench for the task slot round-robin scheduler: a table of
// directed requests followed by constrained-random traffic, each response
// checked against a cycle-free model of the slot table.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Function code 3 has no meaning in the block; it must answer with an
    // all-zero done response and leave the table alone.
    localparam logic [tsrr_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Longest run of cycles with no transaction on either channel that a
    // correct block can show: a full slot scan, a receiver stall, a sender
    // gap, a full command queue ahead, and the drain at the end, all with
    // a wide margin on top.
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = tsrr_pkg::NUM_SLOTS + 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_ITEMS = 150;

    typedef struct packed {
        tsrr_pkg::t_status                status;
        logic [tsrr_pkg::IDX_W-1:0]       slot;
        logic [tsrr_pkg::TID_W-1:0]       tid;
        logic                             sw;
    } t_sched_rsp;

    // One row of the directed table. Where exact is set, the response typed
    // in the row is what the block must return; otherwise the slot table
    // model supplies the expectation.
    typedef struct packed {
        logic [tsrr_pkg::FUNC_W-1:0]      func;
        logic [tsrr_pkg::IDX_W-1:0]       idx;
        logic                             exact;
        t_sched_rsp                       rsp;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Empty table: nothing to run, nothing new to mark.
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_NO_READY, 5'd0,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd5,  1'b1, '{tsrr_pkg::ST_NOT_NEW,  5'd5,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd31, 1'b1, '{tsrr_pkg::ST_NOT_NEW,  5'd31, 32'd0, 1'b0}},
        '{FUNC_SPARE,           5'd31, 1'b1, '{tsrr_pkg::ST_DONE,     5'd0,  32'd0, 1'b0}},
        // Allocation takes the lowest free slot and ignores the index.
        '{tsrr_pkg::FUNC_ALLOC, 5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd0,  32'd1, 1'b0}},
        '{tsrr_pkg::FUNC_ALLOC, 5'd17, 1'b1, '{tsrr_pkg::ST_DONE,     5'd1,  32'd2, 1'b0}},
        '{tsrr_pkg::FUNC_ALLOC, 5'd31, 1'b1, '{tsrr_pkg::ST_DONE,     5'd2,  32'd3, 1'b0}},
        // New slots are not ready, so there is still nothing to run.
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_NO_READY, 5'd0,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd1,  1'b1, '{tsrr_pkg::ST_DONE,     5'd1,  32'd2, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd1,  1'b1, '{tsrr_pkg::ST_NOT_NEW,  5'd1,  32'd0, 1'b0}},
        // First schedule with nothing running scans from slot zero.
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd1,  32'd2, 1'b1}},
        // No other ready slot: the running task is reported and kept.
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_NO_READY, 5'd1,  32'd2, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd0,  32'd1, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd2,  1'b1, '{tsrr_pkg::ST_DONE,     5'd2,  32'd3, 1'b0}},
        // Round-robin from the slot after the running one, wrapping at the top.
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd2,  32'd3, 1'b1}},
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd0,  32'd1, 1'b1}},
        '{tsrr_pkg::FUNC_SCHED, 5'd0,  1'b1, '{tsrr_pkg::ST_DONE,     5'd1,  32'd2, 1'b1}},
        // A running slot is not new.
        '{tsrr_pkg::FUNC_MARK,  5'd1,  1'b1, '{tsrr_pkg::ST_NOT_NEW,  5'd1,  32'd0, 1'b0}},
        '{FUNC_SPARE,           5'd21, 1'b0, '{tsrr_pkg::ST_DONE,     5'd0,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_ALLOC, 5'd10, 1'b1, '{tsrr_pkg::ST_DONE,     5'd3,  32'd4, 1'b0}},
        '{tsrr_pkg::FUNC_MARK,  5'd3,  1'b0, '{tsrr_pkg::ST_DONE,     5'd0,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_SCHED, 5'd14, 1'b0, '{tsrr_pkg::ST_DONE,     5'd0,  32'd0, 1'b0}},
        '{tsrr_pkg::FUNC_SCHED, 5'd27, 1'b0, '{tsrr_pkg::ST_DONE,     5'd0,  32'd0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    tsrr_req_if req_ch ();
    tsrr_rsp_if rsp_ch ();

    task_slot_round_robin_scheduler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Slot table model: state, thread ids, running task and id counter.
    // ------------------------------------------------------------------------
    tsrr_pkg::t_slot_st                tbl_state [tsrr_pkg::NUM_SLOTS];
    logic [tsrr_pkg::TID_W-1:0]        tbl_tid [tsrr_pkg::NUM_SLOTS];
    logic [tsrr_pkg::SLOT_W-1:0]       run_slot;
    logic                              run_valid;
    logic [tsrr_pkg::TID_W-1:0]        tid_counter;

    // Responses owed by the block, oldest first.
    t_sched_rsp         pending_rsp [$];

    int                 fail_count;
    int                 quiet_cycles;
    int                 send_gap_pct;
    int                 stall_pct;
    int                 stall_left;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one request to the model and returns the response it owes.
    function automatic t_sched_rsp apply_request(
        input logic [tsrr_pkg::FUNC_W-1:0] func,
        input logic [tsrr_pkg::IDX_W-1:0]  idx);
        t_sched_rsp r;
        int         k;
        int         s;
        int         pick;
        bit         found;

        r = '{tsrr_pkg::ST_DONE, '0, '0, 1'b0};
        found = 1'b0;
        pick = 0;
        case (func)
            tsrr_pkg::FUNC_ALLOC: begin
                r.status = tsrr_pkg::ST_NO_FREE;
                for (k = 0; k < tsrr_pkg::NUM_SLOTS && !found; k++) begin
                    if (tbl_state[k] == tsrr_pkg::SLOT_FREE) begin
                        found = 1'b1;
                        tbl_state[k] = tsrr_pkg::SLOT_NEW;
                        tbl_tid[k] = tid_counter;
                        tid_counter = tid_counter + 1'b1;
                        r = '{tsrr_pkg::ST_DONE, tsrr_pkg::IDX_W'(k), tbl_tid[k], 1'b0};
                    end
                end
            end
            tsrr_pkg::FUNC_SCHED: begin
                // With a task running, the scan starts just past it; the
                // running slot itself is never ready, so visiting it last
                // changes nothing.
                for (k = 0; k < tsrr_pkg::NUM_SLOTS && !found; k++) begin
                    s = run_valid ? (int'(run_slot) + 1 + k) % tsrr_pkg::NUM_SLOTS : k;
                    if (tbl_state[s] == tsrr_pkg::SLOT_READY) begin
                        found = 1'b1;
                        pick = s;
                    end
                end
                if (!found) begin
                    r.status = tsrr_pkg::ST_NO_READY;
                    if (run_valid) begin
                        r.slot = tsrr_pkg::IDX_W'(run_slot);
                        r.tid = tbl_tid[run_slot];
                    end
                end else begin
                    if (run_valid) begin
                        tbl_state[run_slot] = tsrr_pkg::SLOT_READY;
                    end
                    tbl_state[pick] = tsrr_pkg::SLOT_RUNNING;
                    run_slot = tsrr_pkg::SLOT_W'(pick);
                    run_valid = 1'b1;
                    r = '{tsrr_pkg::ST_DONE, tsrr_pkg::IDX_W'(pick), tbl_tid[pick], 1'b1};
                end
            end
            tsrr_pkg::FUNC_MARK: begin
                if (int'(idx) < tsrr_pkg::NUM_SLOTS
                    && tbl_state[idx] == tsrr_pkg::SLOT_NEW) begin
                    tbl_state[idx] = tsrr_pkg::SLOT_READY;
                    r = '{tsrr_pkg::ST_DONE, idx, tbl_tid[idx], 1'b0};
                end else begin
                    r = '{tsrr_pkg::ST_NOT_NEW, idx, '0, 1'b0};
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Drives one request and waits for its handshake. Valid stays high after
    // the transaction, so back-to-back requests need no extra assignment.
    task automatic issue(input logic [tsrr_pkg::FUNC_W-1:0] func,
                         input logic [tsrr_pkg::IDX_W-1:0] idx,
                         input logic exact, input t_sched_rsp typed);
        t_sched_rsp want;

        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.slot_index <= idx;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        want = apply_request(func, idx);
        pending_rsp.push_back(exact ? typed : want);
    endtask

    // Random sender gap ahead of the next request.
    task automatic maybe_gap();
        int n;

        if ($urandom_range(99, 0) < send_gap_pct) begin
            n = $urandom_range(19, 1);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Holds the request channel idle until every owed response has arrived.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Random request for the main phase. Allocation is kept rare so that the
    // table fills over several hundred requests, and most marks aim at a new
    // slot so that the ready set keeps growing while schedules rotate over it.
    task automatic random_request();
        int                                pct;
        int                                k;
        int                                new_slots [$];
        logic [tsrr_pkg::FUNC_W-1:0]       func;
        logic [tsrr_pkg::IDX_W-1:0]        idx;

        pct = $urandom_range(99, 0);
        idx = tsrr_pkg::IDX_W'($urandom_range(tsrr_pkg::NUM_SLOTS - 1, 0));
        if (pct < 6) begin
            func = tsrr_pkg::FUNC_ALLOC;
        end else if (pct < 26) begin
            func = tsrr_pkg::FUNC_MARK;
            for (k = 0; k < tsrr_pkg::NUM_SLOTS; k++) begin
                if (tbl_state[k] == tsrr_pkg::SLOT_NEW) begin
                    new_slots.push_back(k);
                end
            end
            if (new_slots.size() != 0 && $urandom_range(3, 0) != 0) begin
                idx = tsrr_pkg::IDX_W'(new_slots[$urandom_range(new_slots.size() - 1, 0)]);
            end
        end else if (pct < 94) begin
            func = tsrr_pkg::FUNC_SCHED;
        end else begin
            func = FUNC_SPARE;
        end
        issue(func, idx, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts on ready, and the field checks.
    // ------------------------------------------------------------------------
    initial begin
        rsp_ch.ready <= 1'b0;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(99, 0) < stall_pct) begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(19, 1) - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    t_sched_rsp got_rsp;
    t_sched_rsp want_rsp;

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_rsp = '{tsrr_pkg::t_status'(rsp_ch.status), rsp_ch.result_slot,
                        rsp_ch.thread_id, rsp_ch.switched};
            if (pending_rsp.size() == 0) begin
                $error("response with none owed: status %0d slot %0d tid %0d switched %0d",
                       got_rsp.status, got_rsp.slot, got_rsp.tid, got_rsp.sw);
                fail_count++;
            end else begin
                want_rsp = pending_rsp.pop_front();
                if (got_rsp.status !== want_rsp.status) begin
                    $error("status: expected %0d, actual %0d", want_rsp.status,
                           got_rsp.status);
                    fail_count++;
                end
                if (got_rsp.slot !== want_rsp.slot) begin
                    $error("result_slot: expected %0d, actual %0d", want_rsp.slot,
                           got_rsp.slot);
                    fail_count++;
                end
                if (got_rsp.tid !== want_rsp.tid) begin
                    $error("thread_id: expected %0d, actual %0d", want_rsp.tid,
                           got_rsp.tid);
                    fail_count++;
                end
                if (got_rsp.sw !== want_rsp.sw) begin
                    $error("switched: expected %0d, actual %0d", want_rsp.sw,
                           got_rsp.sw);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel means the
    // block has hung.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** task_slot_round_robin_scheduler: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int row;
        int item;

        fail_count = 0;
        quiet_cycles = 0;
        send_gap_pct = 15;
        stall_pct = 15;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= tsrr_pkg::FUNC_ALLOC;
        req_ch.slot_index <= '0;

        // Model reset mirrors the block: all slots free, nothing running,
        // first thread id one.
        for (row = 0; row < tsrr_pkg::NUM_SLOTS; row++) begin
            tbl_state[row] = tsrr_pkg::SLOT_FREE;
            tbl_tid[row] = '0;
        end
        run_slot = '0;
        run_valid = 1'b0;
        tid_counter = 32'd1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (row = 0; row < DIR_ROWS; row++) begin
            maybe_gap();
            issue(DIRECTED[row].func, DIRECTED[row].idx, DIRECTED[row].exact,
                  DIRECTED[row].rsp);
        end

        // Let the directed part settle completely before random traffic.
        drain_responses();

        for (item = 0; item < RANDOM_ITEMS; item++) begin
            // Re-pick the idling pressure every hundred requests, including
            // stretches with none at all; the tail of the run is kept calm.
            if (item % 100 == 0) begin
                case ($urandom_range(2, 0))
                    0: begin
                        send_gap_pct = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        send_gap_pct = 10;
                        stall_pct = 10;
                    end
                    default: begin
                        send_gap_pct = 30;
                        stall_pct = 30;
                    end
                endcase
            end
            if (item >= RANDOM_ITEMS - CALM_ITEMS) begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            if (item == RANDOM_ITEMS / 3
                || (item < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(149, 0) == 0)) begin
                drain_responses();
            end
            maybe_gap();
            random_request();
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("** task_slot_round_robin_scheduler: PASSED **");
        end else begin
            $display("** task_slot_round_robin_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
